// ===== sv/char_lcd_nibble_write_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble write sequencer
// Shared concurrent check forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define CLNWS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("clnws check failed");

// The condition must never be seen at a clock edge outside reset.
`define CLNWS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("clnws forbidden condition seen");

`endif

// ===== sv/clnws_pkg.sv =====
// ----------------------------------------------------------------------------
// clnws_pkg
// Types, codes and constants shared by the LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package clnws_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int HOLD_W = 6;
    localparam logic [HOLD_W-1:0] HOLD_STROBE   = 6'd2;
    localparam logic [HOLD_W-1:0] HOLD_CMD_TAIL = 6'd7;
    localparam logic [HOLD_W-1:0] HOLD_LONG     = 6'd9;
    localparam logic [HOLD_W-1:0] HOLD_POWER_UP = 6'd45;

    localparam logic [7:0] LINE0_BASE   = 8'h80;
    localparam logic [7:0] LINE1_BASE   = 8'hC0;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    localparam int INIT_LEN = 6;
    localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

    // Reciprocal of ten for 16-bit dividends: q = (v * RECIP10) >> RECIP_SHIFT.
    localparam logic [15:0] RECIP10     = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_CMD    = 3'd0,
        OP_CHAR   = 3'd1,
        OP_NUMBER = 3'd2,
        OP_SETPOS = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_INIT   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_DIGITS,
        FS_INIT
    } t_front_state;

    // One queued job: either a byte to strobe out in four phases, or the
    // single power-up wait phase.
    typedef struct packed {
        logic              wait_ph;
        logic [7:0]        data;
        logic              rs;
        logic [HOLD_W-1:0] tail_hold;
        logic              last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_job mk_job(input logic [7:0] data, input logic rs,
                                    input logic [HOLD_W-1:0] tail_hold,
                                    input logic last);
        t_job j;
        j.wait_ph   = 1'b0;
        j.data      = data;
        j.rs        = rs;
        j.tail_hold = tail_hold;
        j.last      = last;
        return j;
    endfunction

endpackage

// ===== sv/clnws_front.sv =====
// ----------------------------------------------------------------------------
// clnws_front
// Accepts requests, decodes them and pushes byte jobs into the queue.
// ----------------------------------------------------------------------------
module clnws_front
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_row,
    input  logic [5:0]  i_column,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_job        o_job
);

    t_front_state r_state, n_state;
    logic [15:0]          r_val;
    logic [DIG_IDX_W-1:0] r_cnt;
    logic [DIG_IDX_W-1:0] r_idx;
    logic [2:0]           r_init_idx;
    logic [3:0]           r_digits [MAX_DIGITS];

    logic        accept;
    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] rem;
    logic        conv_done;
    t_job        wait_job;

    // Divide by ten: reciprocal multiply, then the remainder by shift-add.
    assign prod      = r_val * RECIP10;
    assign quot      = prod[31:RECIP_SHIFT];
    assign rem       = r_val - ({quot, 3'b000} + {2'b00, quot, 1'b0});
    assign conv_done = (quot == 13'd0) || (r_cnt == DIG_IDX_W'(MAX_DIGITS - 1));

    always_comb begin
        wait_job           = '0;
        wait_job.wait_ph   = 1'b1;
        wait_job.tail_hold = HOLD_POWER_UP;
    end

    always_comb begin
        n_state    = r_state;
        o_push     = 1'b0;
        o_job      = '0;
        o_in_stall = (r_state != FS_IDLE) || i_q_status.full;
        accept     = i_in_valid && !o_in_stall;
        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_CMD: begin
                            o_push = 1'b1;
                            o_job  = mk_job(i_value[7:0], 1'b0, HOLD_CMD_TAIL, 1'b1);
                        end
                        OP_CHAR: begin
                            o_push = 1'b1;
                            o_job  = mk_job(i_value[7:0], 1'b1, HOLD_STROBE, 1'b1);
                        end
                        OP_NUMBER: begin
                            n_state = FS_CONV;
                        end
                        OP_SETPOS: begin
                            if (i_row == 2'd0) begin
                                o_push = 1'b1;
                                o_job  = mk_job(LINE0_BASE + {2'b00, i_column}, 1'b0,
                                                HOLD_CMD_TAIL, 1'b1);
                            end else if (i_row == 2'd1) begin
                                o_push = 1'b1;
                                o_job  = mk_job(LINE1_BASE + {2'b00, i_column}, 1'b0,
                                                HOLD_CMD_TAIL, 1'b1);
                            end
                        end
                        OP_CLEAR: begin
                            o_push = 1'b1;
                            o_job  = mk_job(CMD_CLEAR, 1'b0, HOLD_LONG, 1'b1);
                        end
                        OP_INIT: begin
                            o_push  = 1'b1;
                            o_job   = wait_job;
                            n_state = FS_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FS_CONV: begin
                if (conv_done) begin
                    n_state = FS_DIGITS;
                end
            end
            FS_DIGITS: begin
                if (!i_q_status.full) begin
                    o_push = 1'b1;
                    o_job  = mk_job({ASCII_DIGIT_HI, r_digits[r_idx]}, 1'b1, HOLD_STROBE,
                                    r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            FS_INIT: begin
                if (!i_q_status.full) begin
                    o_push = 1'b1;
                    o_job  = mk_job(INIT_SEQ[r_init_idx], 1'b0, HOLD_LONG,
                                    r_init_idx == 3'(INIT_LEN - 1));
                    if (r_init_idx == 3'(INIT_LEN - 1)) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                r_val      <= i_value;
                r_cnt      <= '0;
                r_init_idx <= '0;
            end
            FS_CONV: begin
                r_digits[r_cnt] <= rem[3:0];
                r_val           <= {3'b000, quot};
                r_cnt           <= r_cnt + 1'b1;
                r_idx           <= r_cnt;
            end
            FS_DIGITS: begin
                if (o_push) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            FS_INIT: begin
                if (o_push) begin
                    r_init_idx <= r_init_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/clnws_queue.sv =====
// ----------------------------------------------------------------------------
// clnws_queue
// Short job queue between the request decoder and the phase generator.
// ----------------------------------------------------------------------------
module clnws_queue
    import clnws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

`include "char_lcd_nibble_write_sequencer_unit_assert.svh"

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CLNWS_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_status.full)
    `CLNWS_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_status.empty)
    `CLNWS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH))

endmodule

// ===== sv/clnws_back.sv =====
// ----------------------------------------------------------------------------
// clnws_back
// Expands queued jobs into pin phases and holds them in the output register.
// ----------------------------------------------------------------------------
module clnws_back
    import clnws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [3:0]        o_data_nibble,
    output logic              o_register_select,
    output logic              o_read_write,
    output logic              o_enable,
    output logic [HOLD_W-1:0] o_hold_ms,
    output logic              o_last
);

    logic [1:0]        r_phase;
    logic              r_valid;
    logic [3:0]        r_nibble;
    logic              r_rs;
    logic              r_en;
    logic [HOLD_W-1:0] r_hold;
    logic              r_last;

    logic              load;
    logic              final_ph;
    logic [3:0]        n_nibble;
    logic              n_en;
    logic [HOLD_W-1:0] n_hold;

    assign load     = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign final_ph = i_head.wait_ph || (r_phase == 2'd3);
    assign o_pop    = load && final_ph;

    // Phases 0 and 1 carry the high nibble, 2 and 3 the low one; enable
    // is high on the even phases.
    always_comb begin
        if (i_head.wait_ph) begin
            n_nibble = 4'h0;
            n_en     = 1'b0;
            n_hold   = i_head.tail_hold;
        end else begin
            n_nibble = r_phase[1] ? i_head.data[3:0] : i_head.data[7:4];
            n_en     = ~r_phase[0];
            n_hold   = (r_phase == 2'd3) ? i_head.tail_hold : HOLD_STROBE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= final_ph ? 2'd0 : r_phase + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nibble <= n_nibble;
            r_rs     <= i_head.rs && !i_head.wait_ph;
            r_en     <= n_en;
            r_hold   <= n_hold;
            r_last   <= final_ph && i_head.last;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_data_nibble     = r_nibble;
    assign o_register_select = r_rs;
    assign o_read_write      = 1'b0;
    assign o_enable          = r_en;
    assign o_hold_ms         = r_hold;
    assign o_last            = r_last;

endmodule

// ===== sv/char_lcd_nibble_write_sequencer_unit.sv =====
// A taken request is decoded into the job queue, and its phases are then loaded
// into the output phase register; a number first runs the divide-by-ten loop,
// one decimal digit per pass, before its digit pushes start. Throughput: one
// phase per cycle while a job is queued and the output is not stalled. A new item
// is taken in any cycle that the front end is idle and the job queue has room.
// Reset (synchronous, active low) empties the queue and the output register.
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Turns LCD requests into 4-bit bus pin phases with their hold times.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_row,
    input  logic [5:0]  i_column,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_data_nibble,
    output logic        o_register_select,
    output logic        o_read_write,
    output logic        o_enable,
    output logic [5:0]  o_hold_ms,
    output logic        o_last
);

    // The front end decodes each item into byte jobs. Simple requests become
    // one job in the cycle they are taken, though a position on row 2 or 3 and
    // an unknown opcode push none. A number is first split into decimal digits,
    // least significant first, and the digits are then pushed most significant
    // first. Init pushes the power-up wait followed by the six setup commands.
    t_job      push_job;
    logic      push;
    t_job      head_job;
    t_q_status q_status;
    logic      pop;

    clnws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The queue lets the decoder run ahead of the phase generator, so the
    // next item is taken while the current one is still being strobed out.
    clnws_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // The back end walks each byte job through its four phases, and the
    // wait job through its single phase, into a registered output stage.
    clnws_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head_job),
        .i_q_status        (q_status),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_data_nibble     (o_data_nibble),
        .o_register_select (o_register_select),
        .o_read_write      (o_read_write),
        .o_enable          (o_enable),
        .o_hold_ms         (o_hold_ms),
        .o_last            (o_last)
    );

endmodule
